>>> rtl/core/assert_macros.svh
// assertion macros used by the ordered value list rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clock edge outside reset
`define OLIST_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("olist check failed");

// same, with a message of its own
`define OLIST_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`endif

>>> rtl/core/olist_pkg.sv
// types and constants of the ordered value list
`default_nettype none

package olist_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int WORD_W    = 32;
    localparam int CNT_OUT_W = 5;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_POP    = 2'd2;
    localparam logic [1:0] KIND_SEARCH = 2'd3;

    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_NOTHING = 2'd2;

    typedef struct packed {
        logic [1:0]               kind;
        logic signed [WORD_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic                 hit;
        logic [CNT_OUT_W-1:0] entry_count;
        logic [1:0]           status;
    } t_out_word;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_SHIFT = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

endpackage

`default_nettype wire

>>> rtl/core/ordered_value_list.sv
// ordered value list: compacted array of signed values in a ram with one write
// port and one read port. One word is taken at a time; the input stalls until
// its result is built. Search reads the entries one per cycle from the head
// through the single ram read port. Delete scans up to the first match at
// position p, then moves the later entries down one per cycle through the same
// read port, so the scan and the move together still visit each entry once. A
// finished result waits in the output register; a new word is taken meanwhile,
// and the next result then holds in the finish state until the output register
// empties. The entry store has no reset and needs no clearing pass.
`default_nettype none

`include "assert_macros.svh"

module ordered_value_list #(
    parameter int DEPTH = olist_pkg::DEPTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire olist_pkg::t_in_word  i_in_word,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output olist_pkg::t_out_word      o_out_word
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    olist_pkg::t_state               r_state, n_state;
    logic [1:0]                      r_kind, n_kind;
    logic signed [olist_pkg::WORD_W-1:0] r_value, n_value;
    logic [CW-1:0]                   r_count, n_count;
    logic [CW-1:0]                   r_idx, n_idx;
    logic                            r_pend, n_pend;
    logic [AW-1:0]                   r_pidx, n_pidx;
    logic                            r_hit, n_hit;
    logic [1:0]                      r_status, n_status;
    logic                            r_out_valid, n_out_valid;
    olist_pkg::t_out_word            r_out_word, n_out_word;

    logic                            we, re;
    logic [AW-1:0]                   waddr;
    logic [olist_pkg::WORD_W-1:0]    wdata;
    logic [olist_pkg::WORD_W-1:0]    rd_data;
    logic                            more;

    olist_ram #(
        .WIDTH (olist_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rd_data)
    );

    assign more = (r_idx < r_count);

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_value     = r_value;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_pidx      = r_pidx;
        n_hit       = r_hit;
        n_status    = r_status;
        n_out_valid = r_out_valid & i_out_stall;
        n_out_word  = r_out_word;
        we          = 1'b0;
        re          = 1'b0;
        waddr       = r_count[AW-1:0];
        wdata       = r_value;

        unique case (r_state)
            olist_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_kind  = i_in_word.kind;
                    n_value = i_in_word.value;
                    n_state = olist_pkg::S_EXEC;
                end
            end
            olist_pkg::S_EXEC: begin
                n_hit    = 1'b0;
                n_status = olist_pkg::STAT_DONE;
                n_idx    = '0;
                n_state  = olist_pkg::S_FIN;
                unique case (r_kind)
                    olist_pkg::KIND_INSERT: begin
                        if (r_count >= DEPTH_C) begin
                            n_status = olist_pkg::STAT_FULL;
                        end else begin
                            we      = 1'b1;
                            n_count = r_count + CW'(1);
                        end
                    end
                    olist_pkg::KIND_POP: begin
                        if (r_count == '0) begin
                            n_status = olist_pkg::STAT_NOTHING;
                        end else begin
                            n_count = r_count - CW'(1);
                        end
                    end
                    olist_pkg::KIND_DELETE, olist_pkg::KIND_SEARCH: begin
                        n_state = olist_pkg::S_SCAN;
                    end
                    default: begin
                        n_state = olist_pkg::S_FIN;
                    end
                endcase
            end
            olist_pkg::S_SCAN: begin
                priority if (r_pend && (rd_data == r_value)) begin
                    n_hit = 1'b1;
                    if (r_kind == olist_pkg::KIND_DELETE) begin
                        n_idx   = CW'(r_pidx) + CW'(1);
                        n_state = olist_pkg::S_SHIFT;
                    end else begin
                        n_state = olist_pkg::S_FIN;
                    end
                end else if (!r_pend && !more) begin
                    if (r_kind == olist_pkg::KIND_DELETE) begin
                        n_status = olist_pkg::STAT_NOTHING;
                    end
                    n_state = olist_pkg::S_FIN;
                end else begin
                    re     = more;
                    n_pend = more;
                    n_pidx = r_idx[AW-1:0];
                    n_idx  = more ? r_idx + CW'(1) : r_idx;
                end
            end
            olist_pkg::S_SHIFT: begin
                // move each later entry down one place
                if (r_pend) begin
                    we    = 1'b1;
                    waddr = r_pidx - AW'(1);
                    wdata = rd_data;
                end
                if (!r_pend && !more) begin
                    n_count = r_count - CW'(1);
                    n_state = olist_pkg::S_FIN;
                end else begin
                    re     = more;
                    n_pend = more;
                    n_pidx = r_idx[AW-1:0];
                    n_idx  = more ? r_idx + CW'(1) : r_idx;
                end
            end
            olist_pkg::S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid            = 1'b1;
                    n_out_word.hit         = r_hit;
                    n_out_word.entry_count = olist_pkg::CNT_OUT_W'(r_count);
                    n_out_word.status      = r_status;
                    n_state                = olist_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = olist_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= olist_pkg::S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_value    <= n_value;
        r_idx      <= n_idx;
        r_pidx     <= n_pidx;
        r_hit      <= n_hit;
        r_status   <= n_status;
        r_out_word <= n_out_word;
    end

    assign o_in_stall  = (r_state != olist_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `OLIST_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= DEPTH_C)
    `OLIST_ASSERT(a_count_step, i_clk, i_rst_n,
        (r_count != $past(r_count)) |-> ((r_count == $past(r_count) + CW'(1)) ||
        (r_count == $past(r_count) - CW'(1))))
    `OLIST_ASSERT_MSG(a_write_state, i_clk, i_rst_n,
        we |-> ((r_state == olist_pkg::S_EXEC) || (r_state == olist_pkg::S_SHIFT)),
        "ram written outside insert or shift")
    `OLIST_ASSERT_MSG(a_result_origin, i_clk, i_rst_n,
        $rose(o_out_valid) |-> ($past(r_state) == olist_pkg::S_FIN),
        "result shown without a finished word")

endmodule

`default_nettype wire

>>> rtl/core/olist_ram.sv
// generic single write port ram with registered read
`default_nettype none

module olist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> test/ordered_value_list_tb.sv
// self-checking testbench, ordered value list: directed and random ops vs shadow list
`default_nettype none

module ordered_value_list_tb;
    import olist_pkg::*;

    localparam int POOL_N = 12;
    localparam logic signed [WORD_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [WORD_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct {
        t_in_word word;
        bit       wait_idle;
    } t_pending;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_word  in_word = '0;
    logic      out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;

    t_pending  pending_ops[$];
    t_out_word due_results[$];
    bit        hold_next = 1'b0;

    logic signed [WORD_W-1:0] list_vals [DEPTH_DEF];
    int        list_len = 0;
    logic signed [WORD_W-1:0] value_pool [POOL_N];

    int        mismatches = 0;
    int        results_seen = 0;
    int        kind_seen [4] = '{0, 0, 0, 0};
    int        full_drops = 0;
    int        misses = 0;
    int        peak_len = 0;

    int        burst_left = 0;
    int        gap_left = 0;
    int        stall_mode = 0;
    int        stall_left = 0;

    ordered_value_list #(.DEPTH(DEPTH_DEF)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (o_out_word)
    );

    always #4 i_clk = ~i_clk;

    function automatic t_out_word list_apply(t_in_word w);
        t_out_word r;
        int        pos;
        bit        found;
        pos = list_len;
        found = 1'b0;
        r.hit = 1'b0;
        r.status = STAT_DONE;
        for (int i = 0; i < list_len; i++) begin
            if (!found && list_vals[i] == w.value) begin
                found = 1'b1;
                pos = i;
            end
        end
        case (w.kind)
            KIND_INSERT: begin
                if (list_len >= DEPTH_DEF) begin
                    r.status = STAT_FULL;
                end else begin
                    list_vals[list_len] = w.value;
                    list_len++;
                end
            end
            KIND_DELETE: begin
                if (found) begin
                    for (int i = pos; i + 1 < list_len; i++) list_vals[i] = list_vals[i + 1];
                    list_len--;
                    r.hit = 1'b1;
                end else begin
                    r.status = STAT_NOTHING;
                end
            end
            KIND_POP: begin
                if (list_len == 0) r.status = STAT_NOTHING;
                else list_len--;
            end
            default: begin
                r.hit = found;
            end
        endcase
        r.entry_count = list_len[CNT_OUT_W-1:0];
        kind_seen[w.kind]++;
        if (r.status == STAT_FULL) full_drops++;
        if (r.status == STAT_NOTHING) misses++;
        if (list_len > peak_len) peak_len = list_len;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("mismatch on result %0d: %s want %0d got %0d", results_seen, what, want, got);
        mismatches++;
    endtask

    task automatic queue_op(input logic [1:0] kind, input logic signed [WORD_W-1:0] value);
        t_pending p;
        p.word.kind = kind;
        p.word.value = value;
        p.wait_idle = hold_next;
        hold_next = 1'b0;
        pending_ops.push_back(p);
    endtask

    function automatic logic [1:0] pick_kind(int phase);
        int roll;
        roll = $urandom_range(0, 99);
        case (phase)
            0: begin
                if (roll < 60) return KIND_INSERT;
                if (roll < 75) return KIND_DELETE;
                if (roll < 80) return KIND_POP;
                return KIND_SEARCH;
            end
            1: begin
                if (roll < 15) return KIND_INSERT;
                if (roll < 50) return KIND_DELETE;
                if (roll < 80) return KIND_POP;
                return KIND_SEARCH;
            end
            default: begin
                if (roll < 35) return KIND_INSERT;
                if (roll < 60) return KIND_DELETE;
                if (roll < 75) return KIND_POP;
                return KIND_SEARCH;
            end
        endcase
    endfunction

    function automatic logic signed [WORD_W-1:0] pick_value();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return value_pool[$urandom_range(0, POOL_N - 1)];
    endfunction

    // driver
    always @(posedge i_clk) begin : drive_proc
        bit took;
        took = 1'b0;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                due_results.push_back(list_apply(in_word));
                took = 1'b1;
            end
            if (!in_valid || took) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (pending_ops.size() == 0 ||
                             (pending_ops[0].wait_idle && due_results.size() != 0)) begin
                    in_valid <= 1'b0;
                end else begin
                    in_word <= pending_ops[0].word;
                    in_valid <= 1'b1;
                    void'(pending_ops.pop_front());
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : watch_proc
        t_out_word want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (due_results.size() == 0) begin
                    report_mismatch("word with nothing expected, count", 0, o_out_word.entry_count);
                end else begin
                    want = due_results.pop_front();
                    if (o_out_word.hit !== want.hit)
                        report_mismatch("hit", want.hit, o_out_word.hit);
                    if (o_out_word.entry_count !== want.entry_count)
                        report_mismatch("entry_count", want.entry_count, o_out_word.entry_count);
                    if (o_out_word.status !== want.status)
                        report_mismatch("status", want.status, o_out_word.status);
                end
                results_seen++;
            end
            if (stall_left == 0) begin
                stall_mode <= $urandom_range(0, 2);
                stall_left <= $urandom_range(20, 120);
            end else begin
                stall_left <= stall_left - 1;
            end
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 2) == 0);
                default: out_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #3200000;
        $display("timeout");
        $display("FAIL ordered_value_list");
        $finish;
    end

    initial begin : stim_proc
        int phase;
        int phase_left;
        phase = 2;
        phase_left = 0;
        value_pool[0] = VAL_MIN;
        value_pool[1] = VAL_MAX;
        value_pool[2] = 0;
        value_pool[3] = -1;
        value_pool[4] = 1;
        for (int i = 5; i < POOL_N; i++) value_pool[i] = $urandom;

        // empty list
        queue_op(KIND_SEARCH, 0);
        queue_op(KIND_POP, $urandom);
        queue_op(KIND_DELETE, 5);
        // fill with extremes and a duplicate
        queue_op(KIND_INSERT, VAL_MIN);
        queue_op(KIND_INSERT, VAL_MAX);
        queue_op(KIND_INSERT, 0);
        queue_op(KIND_INSERT, -1);
        queue_op(KIND_INSERT, 7);
        queue_op(KIND_INSERT, 7);
        for (int i = 0; i < DEPTH_DEF - 6; i++) queue_op(KIND_INSERT, $urandom);
        // full list
        queue_op(KIND_INSERT, 123);
        queue_op(KIND_SEARCH, VAL_MAX);
        queue_op(KIND_SEARCH, 32'sh1234_5678);
        queue_op(KIND_DELETE, 7);
        queue_op(KIND_SEARCH, 7);
        queue_op(KIND_DELETE, 32'sh0bad_f00d);
        queue_op(KIND_DELETE, VAL_MIN);
        queue_op(KIND_POP, 0);

        hold_next = 1'b1;
        for (int n = 0; n < 400; n++) begin
            if (phase_left == 0) begin
                phase = $urandom_range(0, 2);
                phase_left = $urandom_range(15, 60);
            end
            phase_left--;
            if (n % 100 == 50) hold_next = 1'b1;
            if ($urandom_range(0, 15) == 0) value_pool[$urandom_range(0, POOL_N - 1)] = $urandom;
            queue_op(pick_kind(phase), pick_value());
        end

        while (!i_rst_n || pending_ops.size() != 0 || in_valid || due_results.size() != 0)
            @(posedge i_clk);
        repeat (64) @(posedge i_clk);

        $display("ran %0d words: %0d insert, %0d delete, %0d pop, %0d search",
                 results_seen, kind_seen[KIND_INSERT], kind_seen[KIND_DELETE],
                 kind_seen[KIND_POP], kind_seen[KIND_SEARCH]);
        $display("full drops %0d, empty or unmatched removals %0d, deepest list %0d, errors %0d",
                 full_drops, misses, peak_len, mismatches);
        if (mismatches == 0) begin
            $display("PASS ordered_value_list");
        end else begin
            $display("FAIL ordered_value_list");
        end
        $finish;
    end

endmodule

`default_nettype wire
